// ----- design/strmq_pkg.sv -----
// Package: constants, payload structs and queue entry type for the range-minimum engine.
package strmq_pkg;
  localparam int MaxElements = 1024;
  localparam int NumLevels   = 11;
  localparam int ValueBits   = 32;
  localparam int IdxBits     = $clog2(MaxElements);
  localparam int CntBits     = IdxBits + 1;
  localparam int LvlBits     = $clog2(NumLevels);
  localparam int CellBits    = ValueBits + IdxBits;
  localparam int AddrBits    = $clog2(NumLevels * MaxElements);

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef struct packed {
    logic                        mode;
    logic signed [ValueBits-1:0] value;
    logic                        last;
    logic [IdxBits-1:0]          left_index;
    logic [IdxBits-1:0]          right_index;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] min_value;
    logic [IdxBits-1:0]          min_index;
    logic                        status;
  } out_item_t;

  typedef enum logic [1:0] {
    OpStore = 2'd0,
    OpBuild = 2'd1,
    OpQuery = 2'd2,
    OpFlag  = 2'd3
  } op_e;

  // Classified command from front to back
  typedef struct packed {
    op_e                         op;
    logic signed [ValueBits-1:0] value;
    logic [IdxBits-1:0]          addr;
    logic [IdxBits-1:0]          left_index;
    logic [IdxBits-1:0]          right_index;
    logic [CntBits-1:0]          count;
  } cmd_t;

  function automatic logic [AddrBits-1:0] cell_addr(logic [LvlBits-1:0] lvl,
                                                   logic [IdxBits-1:0] idx);
    logic [AddrBits+LvlBits-1:0] a;
    a = (AddrBits+LvlBits)'(lvl) * (AddrBits+LvlBits)'(MaxElements) +
        (AddrBits+LvlBits)'(idx);
    return a[AddrBits-1:0];
  endfunction

  function automatic logic [LvlBits-1:0] floor_log2(logic [CntBits-1:0] n);
    logic [LvlBits-1:0] k;
    k = '0;
    for (int i = 1; i < CntBits; i++) begin
      if (n[i]) k = LvlBits'(i);
    end
    return k;
  endfunction
endpackage

// ----- design/sparse_table_range_minimum.sv -----
// Top level of the sparse-table range-minimum query engine.
// Loads store one value a cycle while the queue accepts them. The load marked last holds
// the input until its build command is queued; the build then walks every table entry of
// levels one and up through the single table RAM (one read port), reading two entries and
// writing their minimum, and commands behind it wait. A query result is registered after
// two RAM reads and a compare, and the back end takes no new command until it is done.
// Flagged queries are registered at their transfer and are valid in the next cycle.
// Results are held in an output register; a held result stalls only queries and flags.
module sparse_table_range_minimum import strmq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  logic cmd_valid, cmd_ready, q_valid, q_ready, q_drop, drop;
  cmd_t cmd, q_cmd;

  // Mark non-result flags from loads past capacity
  assign drop = cmd.op == OpFlag && in_data.mode == ModeLoad;

  strmq_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  strmq_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(cmd_valid), .push_ready_o(cmd_ready), .push_data_i(cmd),
    .push_drop_i(drop),
    .pop_valid_o(q_valid), .pop_ready_i(q_ready), .pop_data_o(q_cmd),
    .pop_drop_o(q_drop)
  );

  strmq_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd), .cmd_drop_i(q_drop),
    .out_valid, .out_ready, .out_data
  );
endmodule

// ----- design/strmq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module strmq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- design/strmq_front.sv -----
// Front end: accepts items, tracks array length and readiness, classifies commands.
module strmq_front import strmq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);
  logic [CntBits-1:0] count_q, count_d;
  logic               ready_q, ready_d;
  logic [CntBits-1:0] base;
  logic               room;

  // A build must be queued behind the store, so a last load needs two slots: take
  // the store now and the build as a second step.
  logic build_pend_q, build_pend_d;

  assign in_ready    = cmd_ready_i && !build_pend_q;
  assign cmd_valid_o = build_pend_q || in_valid;
  assign base        = ready_q ? '0 : count_q;
  assign room        = base < CntBits'(MaxElements);

  always_comb begin
    count_d      = count_q;
    ready_d      = ready_q;
    build_pend_d = build_pend_q;
    cmd_o        = '0;
    cmd_o.value  = in_data.value;
    cmd_o.addr   = base[IdxBits-1:0];
    cmd_o.left_index  = in_data.left_index;
    cmd_o.right_index = in_data.right_index;
    cmd_o.count  = count_q;
    if (build_pend_q) begin
      cmd_o.op = OpBuild;
      if (cmd_ready_i) begin
        build_pend_d = 1'b0;
        ready_d      = 1'b1;
      end
    end else if (in_data.mode == ModeLoad) begin
      // Store while there is room; past capacity a last load still builds, others drop
      if (room)              cmd_o.op = OpStore;
      else if (in_data.last) cmd_o.op = OpBuild;
      else                   cmd_o.op = OpFlag;
      if (in_valid && cmd_ready_i) begin
        count_d = room ? base + 1'b1 : base;
        ready_d = 1'b0;
        if (in_data.last) begin
          if (room) build_pend_d = 1'b1;
          else      ready_d = 1'b1;
        end
      end
      cmd_o.count = room ? base + 1'b1 : base;
    end else begin
      if (!ready_q || count_q == '0 || in_data.left_index > in_data.right_index ||
          CntBits'(in_data.right_index) >= count_q)
        cmd_o.op = OpFlag;
      else
        cmd_o.op = OpQuery;
    end
  end

  // Hold array length, readiness and the pending build
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ready_q      <= 1'b0;
      build_pend_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      ready_q      <= ready_d;
      build_pend_q <= build_pend_d;
    end
  end
endmodule

// ----- design/strmq_queue.sv -----
// Two-entry command queue between front and back ends.
module strmq_queue import strmq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  input  logic push_drop_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o,
  output logic pop_drop_o
);
  cmd_t       data_q [2];
  logic [1:0] drop_q;
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign push_ready_o = fill_q != 2'd2;
  assign pop_valid_o  = fill_q != 2'd0;
  assign pop_data_o   = data_q[rd_q];
  assign pop_drop_o   = drop_q[rd_q];

  // Advance pointers on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= '0;
      drop_q <= '0;
    end else begin
      if (push_valid_i && push_ready_o) begin
        wr_q         <= ~wr_q;
        drop_q[wr_q] <= push_drop_i;
      end
      if (pop_valid_o && pop_ready_i) rd_q <= ~rd_q;
      fill_q <= fill_q + 2'((push_valid_i && push_ready_o) ? 1 : 0)
                       - 2'((pop_valid_o && pop_ready_i) ? 1 : 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) data_q[wr_q] <= push_data_i;
  end
endmodule

// ----- design/strmq_back.sv -----
// Back end: writes loads, sweeps the table build and answers queries from the RAM.
module strmq_back import strmq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  input  logic      cmd_drop_i,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  typedef enum logic [2:0] {
    StIdle, StBuildRdA, StBuildRdB, StBuildWr, StQryB, StQryCmp
  } state_e;

  state_e             state_q;
  logic [LvlBits-1:0] lvl_q;
  logic [IdxBits-1:0] j_q;
  logic [CntBits-1:0] cnt_q;
  logic [IdxBits-1:0] half_q;
  logic [CellBits-1:0] a_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic                we;
  logic [AddrBits-1:0] waddr, raddr;
  logic [CellBits-1:0] wdata, rdata;
  logic [CellBits-1:0] best;
  logic [LvlBits-1:0]  qk;
  logic [CntBits-1:0]  qlen;
  logic [IdxBits-1:0]  qright;
  logic                take;
  logic                res_load;

  strmq_ram #(.Width(CellBits), .Depth(NumLevels * MaxElements)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_valid   = out_valid_q;
  assign out_data    = out_q;
  // Only queries and flags wait for the output register, dropped flags included
  assign take        = state_q == StIdle && cmd_valid_i &&
                       (cmd_i.op == OpStore || cmd_i.op == OpBuild ||
                        !out_valid_q || out_ready);
  assign cmd_ready_o = take;
  assign res_load    = (take && cmd_i.op == OpFlag && !cmd_drop_i) || state_q == StQryCmp;

  assign qlen   = CntBits'(cmd_i.right_index) - CntBits'(cmd_i.left_index) + 1'b1;
  assign qk     = floor_log2(qlen);
  assign qright = cmd_i.right_index + 1'b1 - IdxBits'(1 << qk);

  // Left entry sits in a_q, right entry in rdata; right-hand entry wins a tie
  assign best = ($signed(a_q[CellBits-1 -: ValueBits]) <
                 $signed(rdata[CellBits-1 -: ValueBits])) ? a_q : rdata;

  always_comb begin
    we    = 1'b0;
    waddr = cell_addr('0, cmd_i.addr);
    wdata = {cmd_i.value, cmd_i.addr};
    raddr = cell_addr(lvl_q - 1'b1, j_q);
    if (take && cmd_i.op == OpStore && !cmd_drop_i) we = 1'b1;
    if (take && cmd_i.op == OpQuery) raddr = cell_addr(qk, cmd_i.left_index);
    if (state_q == StQryB) raddr = cell_addr(lvl_q, j_q);
    if (state_q == StBuildRdB) raddr = cell_addr(lvl_q - 1'b1, j_q + half_q);
    if (state_q == StBuildWr) begin
      we    = 1'b1;
      waddr = cell_addr(lvl_q, j_q);
      wdata = best;
    end
  end

  // Sequence builds and queries, hold the result until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      lvl_q       <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      half_q      <= '0;
    end else begin
      if (res_load)       out_valid_q <= 1'b1;
      else if (out_ready) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (take) begin
            case (cmd_i.op)
              OpBuild: begin
                cnt_q  <= cmd_i.count;
                lvl_q  <= LvlBits'(1);
                half_q <= IdxBits'(1);
                j_q    <= '0;
                if (NumLevels > 1 && cmd_i.count >= CntBits'(2)) state_q <= StBuildRdA;
              end
              OpQuery: begin
                j_q     <= qright;
                lvl_q   <= qk;
                state_q <= StQryB;
              end
              OpFlag: begin
                if (!cmd_drop_i) begin
                  out_q <= '{min_value: '0, min_index: '0, status: 1'b1};
                end
              end
              default: ;
            endcase
          end
        end
        StQryB: begin
          // Left block now in rdata; right block read is issued
          a_q     <= rdata;
          state_q <= StQryCmp;
        end
        StQryCmp: begin
          out_q.min_value <= $signed(best[CellBits-1 -: ValueBits]);
          out_q.min_index <= best[IdxBits-1:0];
          out_q.status    <= 1'b0;
          state_q         <= StIdle;
        end
        StBuildRdA: state_q <= StBuildRdB;
        StBuildRdB: begin
          a_q     <= rdata;
          state_q <= StBuildWr;
        end
        StBuildWr: begin
          if ((CntBits+1)'(j_q) + ((CntBits+1)'(half_q) << 1) + 1'b1 <=
              (CntBits+1)'(cnt_q)) begin
            j_q     <= j_q + 1'b1;
            state_q <= StBuildRdA;
          end else if (32'(lvl_q) + 1 < NumLevels &&
                       ((CntBits+2)'(half_q) << 2) <= (CntBits+2)'(cnt_q)) begin
            lvl_q   <= lvl_q + 1'b1;
            half_q  <= half_q << 1;
            j_q     <= '0;
            state_q <= StBuildRdA;
          end else begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
